/* hw/rtl/bpa_pkg.sv */
`timescale 1ns / 1ps
package bpa_pkg;

	localparam int RANK_CAP  = 16;
	localparam int PAGE_W    = 15;
	localparam int RANK_W    = 5;
	localparam int POS_W     = 16;
	localparam int WORD_AW   = 11;
	localparam int FM_WORDS  = 2048;
	localparam int AM_DEPTH  = 32768;
	localparam int TALLY_W   = 16;

	typedef enum logic [2:0] {
		ACT_ALLOC   = 3'd0,
		ACT_RETURN  = 3'd1,
		ACT_QRANK   = 3'd2,
		ACT_QCOUNT  = 3'd3,
		ACT_RESTART = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_INVAL   = 2'd1,
		STS_NOSPACE = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_SEED, ST_IDLE,
		ST_A_FIND, ST_A_RD, ST_A_CHK, ST_A_TAKE, ST_A_SPLIT,
		ST_R_RD, ST_R_CHK, ST_R_MRD, ST_R_MCHK, ST_R_SET,
		ST_Q_RD, ST_Q_CHK, ST_Q_FRD, ST_Q_FCHK
	} state_t;

	// Command bundle from the sequencer to the storage.
	typedef struct packed {
		logic [WORD_AW-1:0] fm_raddr;
		logic               fm_we;
		logic               fm_all;
		logic [WORD_AW-1:0] fm_waddr;
		logic [4:0]         fm_wbit;
		logic               fm_wval;
		logic [PAGE_W-1:0]  am_addr;
		logic               am_we;
		logic [RANK_W-1:0]  am_wdata;
	} store_cmd_t;

	// Flat bit position of rank r's first block in the free map.
	function automatic logic [POS_W-1:0] rank_base(input logic [RANK_W-1:0] r);
		logic [16:0] t;
		t = 17'd1 << 5'(5'd17 - r);
		return POS_W'(17'h10000 - t);
	endfunction

endpackage

/* hw/rtl/buddy_page_allocator.sv */
`timescale 1ns / 1ps
// Channel   | Ports                               | Handshake
// ----------+-------------------------------------+-----------------------------
// command   | action, req_rank, page_index        | taken when start & !busy
// result    | status, out_page, value             | done high for one cycle
// config    | cfg_data (top_rank)                 | written when cfg_we is high
//
// One item per command. A count query is answered from the idle state; a page rank
// query reads the page mark, then walks the free map down from the top rank; a return
// merges with its buddy level by level; and an allocate takes up to 16 rank steps,
// then scans 32-bit free map words (at most 1024 words), then splits once per rank;
// the single free map read port sets this pace. Reset and every restart run a clearing
// pass over all 32768 page marks and then a seed step while busy is high; a restart
// gives its result in the seed step.
// The receiver cannot stall: each result is shown for exactly one cycle.
module buddy_page_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 action,
	input  logic [4:0]                 req_rank,
	input  logic [bpa_pkg::PAGE_W-1:0] page_index,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [bpa_pkg::PAGE_W-1:0] out_page,
	output logic [15:0]                value,
	input  logic                       cfg_we,
	input  logic [4:0]                 cfg_data
);
	import bpa_pkg::*;

	state_t state_q, state_d;

	logic [RANK_W-1:0] top_q;
	logic [RANK_W-1:0] arank_q, arank_d;
	logic [RANK_W-1:0] rank_q, rank_d;
	logic [PAGE_W-1:0] page_q, page_d;
	logic [RANK_W-1:0] k_q, k_d;
	logic [PAGE_W-1:0] idx_q, idx_d;
	logic [WORD_AW-1:0] w_q, w_d;
	logic [PAGE_W-1:0] clr_q, clr_d;
	logic              pend_q, pend_d;
	logic [TALLY_W-1:0] tally_q [RANK_CAP];

	logic        done_q;
	logic [1:0]  status_q;
	logic [PAGE_W-1:0] opage_q;
	logic [15:0] value_q;

	logic        res_v;
	logic [1:0]  res_status;
	logic [PAGE_W-1:0] res_page;
	logic [15:0] res_value;

	logic        tal_rst, tal_inc, tal_dec;
	logic [3:0]  tal_idx;

	store_cmd_t  cmd;
	logic [31:0] fm_rdata;
	logic [4:0]  am_rdata;

	logic        ffs_found;
	logic [4:0]  ffs_bit;
	logic [POS_W-1:0] base_k;
	logic [POS_W:0]   hi_k;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] fpos;
	logic [RANK_W-1:0] clamp_rank;
	logic        rank_ok, page_ok, mark_ok;

	bpa_store u_store (
		.clk      (clk),
		.cmd      (cmd),
		.fm_rdata (fm_rdata),
		.am_rdata (am_rdata)
	);

	// Window of the current rank's blocks inside the flat free map.
	assign base_k = rank_base(k_q);
	assign hi_k   = {1'b0, base_k} + ((POS_W+1)'(1) << 5'(arank_q - k_q));

	bpa_ffs u_ffs (
		.word    (fm_rdata),
		.waddr   (w_q),
		.lo      (base_k),
		.hi      (hi_k),
		.found   (ffs_found),
		.bit_sel (ffs_bit)
	);

	assign fpos       = {w_q, ffs_bit};
	assign clamp_rank = (top_q == '0) ? RANK_W'(1) :
		(top_q > RANK_W'(RANK_CAP)) ? RANK_W'(RANK_CAP) : top_q;
	assign rank_ok    = (rank_q != '0) && (rank_q <= arank_q);
	assign page_ok    = (page_q >> 4'(arank_q - 5'd1)) == '0;
	assign mark_ok    = (am_rdata != '0) && (am_rdata <= arank_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= RANK_W'(RANK_CAP);
		end else if (cfg_we) begin
			top_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			arank_q <= RANK_W'(RANK_CAP);
			clr_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			arank_q <= arank_d;
			clr_q   <= clr_d;
			pend_q  <= pend_d;
			done_q  <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		rank_q <= rank_d;
		page_q <= page_d;
		k_q    <= k_d;
		idx_q  <= idx_d;
		w_q    <= w_d;
		if (res_v) begin
			status_q <= res_status;
			opage_q  <= res_page;
			value_q  <= res_value;
		end
	end

	// Free block counts per rank; one change per cycle at most.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RANK_CAP; i++) begin
				tally_q[i] <= (i == RANK_CAP - 1) ? TALLY_W'(1) : '0;
			end
		end else if (tal_rst) begin
			for (int i = 0; i < RANK_CAP; i++) begin
				tally_q[i] <= (4'(i) == tal_idx) ? TALLY_W'(1) : '0;
			end
		end else if (tal_inc) begin
			tally_q[tal_idx] <= tally_q[tal_idx] + TALLY_W'(1);
		end else if (tal_dec) begin
			tally_q[tal_idx] <= tally_q[tal_idx] - TALLY_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		arank_d = arank_q;
		rank_d  = rank_q;
		page_d  = page_q;
		k_d     = k_q;
		idx_d   = idx_q;
		w_d     = w_q;
		clr_d   = clr_q;
		pend_d  = pend_q;
		res_v      = 1'b0;
		res_status = STS_INVAL;
		res_page   = '0;
		res_value  = '0;
		tal_rst = 1'b0;
		tal_inc = 1'b0;
		tal_dec = 1'b0;
		tal_idx = 4'(k_q - 5'd1);
		pos     = base_k + POS_W'(idx_q);
		cmd     = '0;
		cmd.fm_raddr = pos[POS_W-1:5];
		cmd.fm_waddr = pos[POS_W-1:5];
		cmd.fm_wbit  = pos[4:0];
		cmd.am_addr  = page_q;

		unique case (state_q)
			ST_CLEAR: begin
				// Zero the page marks, and the free map words along the way.
				cmd.am_addr  = clr_q;
				cmd.am_we    = 1'b1;
				cmd.am_wdata = '0;
				cmd.fm_waddr = clr_q[WORD_AW-1:0];
				cmd.fm_all   = 1'b1;
				cmd.fm_we    = (clr_q[PAGE_W-1:WORD_AW] == '0);
				clr_d = clr_q + PAGE_W'(1);
				if (clr_q == '1) begin
					state_d = ST_SEED;
				end
			end
			ST_SEED: begin
				pos          = rank_base(arank_q);
				cmd.fm_waddr = pos[POS_W-1:5];
				cmd.fm_wbit  = pos[4:0];
				cmd.fm_we    = 1'b1;
				cmd.fm_wval  = 1'b1;
				if (pend_q) begin
					res_v      = 1'b1;
					res_status = STS_OK;
				end
				pend_d  = 1'b0;
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					rank_d = req_rank;
					page_d = page_index;
					k_d    = req_rank;
					case (action)
						ACT_ALLOC: begin
							if (req_rank != '0 && req_rank <= arank_q) begin
								state_d = ST_A_FIND;
							end else begin
								res_v = 1'b1;
							end
						end
						ACT_RETURN: state_d = ST_R_RD;
						ACT_QRANK:  state_d = ST_Q_RD;
						ACT_QCOUNT: begin
							res_v = 1'b1;
							if (req_rank != '0 && req_rank <= arank_q) begin
								res_status = STS_OK;
								res_value  = tally_q[4'(req_rank - 5'd1)];
							end
						end
						ACT_RESTART: begin
							arank_d = clamp_rank;
							tal_rst = 1'b1;
							tal_idx = 4'(clamp_rank - 5'd1);
							clr_d   = '0;
							pend_d  = 1'b1;
							state_d = ST_CLEAR;
						end
						default: res_v = 1'b1;
					endcase
				end
			end
			ST_A_FIND: begin
				// Smallest rank with a free block, from the requested rank up.
				if (tally_q[tal_idx] != '0) begin
					w_d     = base_k[POS_W-1:5];
					state_d = ST_A_RD;
				end else if (k_q == arank_q) begin
					res_v      = 1'b1;
					res_status = STS_NOSPACE;
					state_d    = ST_IDLE;
				end else begin
					k_d = k_q + RANK_W'(1);
				end
			end
			ST_A_RD: begin
				cmd.fm_raddr = w_q;
				state_d      = ST_A_CHK;
			end
			ST_A_CHK: begin
				if (ffs_found) begin
					idx_d   = PAGE_W'(fpos - base_k);
					state_d = ST_A_TAKE;
				end else begin
					w_d     = w_q + WORD_AW'(1);
					state_d = ST_A_RD;
				end
			end
			ST_A_TAKE: begin
				cmd.fm_we   = 1'b1;
				cmd.fm_wval = 1'b0;
				tal_dec     = 1'b1;
				state_d     = ST_A_SPLIT;
			end
			ST_A_SPLIT: begin
				if (k_q > rank_q) begin
					// Free the right half one rank down and keep the left half.
					pos          = rank_base(k_q - RANK_W'(1)) + POS_W'({idx_q[PAGE_W-2:0], 1'b1});
					cmd.fm_waddr = pos[POS_W-1:5];
					cmd.fm_wbit  = pos[4:0];
					cmd.fm_we    = 1'b1;
					cmd.fm_wval  = 1'b1;
					tal_inc      = 1'b1;
					tal_idx      = 4'(k_q - 5'd2);
					idx_d        = idx_q << 1;
					k_d          = k_q - RANK_W'(1);
				end else begin
					res_page     = idx_q << 4'(rank_q - 5'd1);
					cmd.am_addr  = res_page;
					cmd.am_we    = 1'b1;
					cmd.am_wdata = rank_q;
					res_v        = 1'b1;
					res_status   = STS_OK;
					state_d      = ST_IDLE;
				end
			end
			ST_R_RD: begin
				if (page_ok) begin
					state_d = ST_R_CHK;
				end else begin
					res_v   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_R_CHK: begin
				if (mark_ok) begin
					cmd.am_we    = 1'b1;
					cmd.am_wdata = '0;
					k_d          = am_rdata;
					idx_d        = page_q >> 4'(am_rdata - 5'd1);
					state_d      = ST_R_MRD;
				end else begin
					res_v   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_R_MRD: begin
				pos          = base_k + POS_W'(idx_q ^ PAGE_W'(1));
				cmd.fm_raddr = pos[POS_W-1:5];
				state_d      = (k_q < arank_q) ? ST_R_MCHK : ST_R_SET;
			end
			ST_R_MCHK: begin
				// Merge with the buddy while it is free.
				pos = base_k + POS_W'(idx_q ^ PAGE_W'(1));
				if (fm_rdata[pos[4:0]]) begin
					cmd.fm_waddr = pos[POS_W-1:5];
					cmd.fm_wbit  = pos[4:0];
					cmd.fm_we    = 1'b1;
					cmd.fm_wval  = 1'b0;
					tal_dec      = 1'b1;
					idx_d        = idx_q >> 1;
					k_d          = k_q + RANK_W'(1);
					state_d      = ST_R_MRD;
				end else begin
					state_d = ST_R_SET;
				end
			end
			ST_R_SET: begin
				cmd.fm_we   = 1'b1;
				cmd.fm_wval = 1'b1;
				tal_inc     = 1'b1;
				res_v       = 1'b1;
				res_status  = STS_OK;
				state_d     = ST_IDLE;
			end
			ST_Q_RD: begin
				if (page_ok) begin
					state_d = ST_Q_CHK;
				end else begin
					res_v   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_Q_CHK: begin
				if (mark_ok) begin
					res_v      = 1'b1;
					res_status = STS_OK;
					res_value  = 16'(am_rdata);
					state_d    = ST_IDLE;
				end else begin
					k_d     = arank_q;
					state_d = ST_Q_FRD;
				end
			end
			ST_Q_FRD: begin
				pos          = base_k + POS_W'(page_q >> 4'(k_q - 5'd1));
				cmd.fm_raddr = pos[POS_W-1:5];
				state_d      = ST_Q_FCHK;
			end
			ST_Q_FCHK: begin
				// Walk down from the top rank for a free block holding the page.
				pos = base_k + POS_W'(page_q >> 4'(k_q - 5'd1));
				if (fm_rdata[pos[4:0]]) begin
					res_v      = 1'b1;
					res_status = STS_OK;
					res_value  = 16'(k_q);
					state_d    = ST_IDLE;
				end else if (k_q == RANK_W'(1)) begin
					res_v   = 1'b1;
					state_d = ST_IDLE;
				end else begin
					k_d     = k_q - RANK_W'(1);
					state_d = ST_Q_FRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign status   = status_q;
	assign out_page = opage_q;
	assign value    = value_q;

endmodule

/* hw/rtl/bpa_store.sv */
`timescale 1ns / 1ps
module bpa_store (
	input  logic                clk,
	input  bpa_pkg::store_cmd_t cmd,
	output logic [31:0]         fm_rdata,
	output logic [4:0]          am_rdata
);
	import bpa_pkg::*;

	logic [31:0]       fm_mem [FM_WORDS];
	logic [RANK_W-1:0] am_mem [AM_DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.fm_we) begin
			if (cmd.fm_all) begin
				fm_mem[cmd.fm_waddr] <= '0;
			end else begin
				fm_mem[cmd.fm_waddr][cmd.fm_wbit] <= cmd.fm_wval;
			end
		end
		fm_rdata <= fm_mem[cmd.fm_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.am_we) begin
			am_mem[cmd.am_addr] <= cmd.am_wdata;
		end
		am_rdata <= am_mem[cmd.am_addr];
	end

endmodule

/* hw/rtl/bpa_ffs.sv */
`timescale 1ns / 1ps
module bpa_ffs (
	input  logic [31:0]                 word,
	input  logic [bpa_pkg::WORD_AW-1:0] waddr,
	input  logic [bpa_pkg::POS_W-1:0]   lo,
	input  logic [bpa_pkg::POS_W:0]     hi,
	output logic                        found,
	output logic [4:0]                  bit_sel
);
	import bpa_pkg::*;

	logic [POS_W-1:0] p;

	// Lowest set bit whose flat position lies inside [lo, hi).
	always_comb begin
		found   = 1'b0;
		bit_sel = '0;
		p       = '0;
		for (int b = 31; b >= 0; b--) begin
			p = {waddr, 5'(b)};
			if (word[b] && p >= lo && {1'b0, p} < hi) begin
				found   = 1'b1;
				bit_sel = 5'(b);
			end
		end
	end

endmodule
